[rtl/core/tpdds_pkg.sv]
`timescale 1ns / 1ps

package tpdds_pkg;

	// payload widths fixed by the item fields
	localparam int PHASE_W = 32;
	localparam int IDX_W   = 10;
	localparam int CODE_W  = 12;
	localparam int REQ_W   = 2;

	// waveform table
	localparam int TBL_DEPTH = 1024;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	// phase bits that address the table: floor(log2(depth))
	localparam int RD_BITS   = $clog2(TBL_DEPTH + 1) - 1;
	localparam logic [CODE_W-1:0] RESET_CODE = CODE_W'(1241);

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE = REQ_W'(0);
	localparam logic [REQ_W-1:0] REQ_WRITE  = REQ_W'(1);
	localparam logic [REQ_W-1:0] REQ_PHASE  = REQ_W'(2);

	// queues
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_SAMPLE,
		CMD_WRITE,
		CMD_PHASE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [TBL_AW-1:0]    addr;
		logic [CODE_W-1:0]    code;
		logic [PHASE_W-1:0]   phase;
	} cmd_t;

	typedef struct packed {
		logic                 clearing;
		logic [OUTQ_CW-1:0]   out_cnt;
		logic [1:0]           inflight;
	} back_stat_t;

endpackage

[rtl/core/tpdds_front.sv]
`timescale 1ns / 1ps

module tpdds_front import tpdds_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [IDX_W-1:0]     table_index,
	input  logic [CODE_W-1:0]    table_value,
	input  logic [PHASE_W-1:0]   phase_value,
	input  logic                 clearing,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_cls;
	logic useful;
	logic accept;

	// classify the incoming item
	always_comb begin
		cmd_cls.kind  = CMD_SAMPLE;
		cmd_cls.addr  = TBL_AW'(table_index);
		cmd_cls.code  = table_value;
		cmd_cls.phase = phase_value;
		useful        = 1'b0;
		case (req_type)
			REQ_SAMPLE: begin
				cmd_cls.kind = CMD_SAMPLE;
				useful       = 1'b1;
			end
			REQ_WRITE: begin
				cmd_cls.kind = CMD_WRITE;
				useful       = (32'(table_index) < 32'(TBL_DEPTH));
			end
			REQ_PHASE: begin
				cmd_cls.kind = CMD_PHASE;
				useful       = 1'b1;
			end
			default: begin
				useful = 1'b0;
			end
		endcase
	end

	assign q_push = valid_s1 && !q_full;
	assign q_cmd  = cmd_s1;
	assign full   = clearing || (valid_s1 && q_full);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= useful;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_cls;
		end
	end

endmodule

[rtl/core/tpdds_cmd_q.sv]
`timescale 1ns / 1ps

module tpdds_cmd_q import tpdds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  cmd_t   wr_cmd,
	output logic   q_full,
	input  logic   rd_en,
	output cmd_t   rd_cmd,
	output logic   q_empty
);

	cmd_t                slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_CW-1:0]  cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign q_full  = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[rtl/core/tpdds_back.sv]
`timescale 1ns / 1ps

module tpdds_back import tpdds_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PHASE_W-1:0]   tuning_word,
	input  logic                 q_empty,
	input  cmd_t                 q_cmd,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [CODE_W-1:0]    sample,
	output back_stat_t           stat
);

	// table clear after reset
	logic                 clearing_q;
	logic [TBL_AW-1:0]    clr_addr_q;

	// phase accumulator
	logic [PHASE_W-1:0]   phase_q;
	logic [PHASE_W-1:0]   phase_sum;

	// stage 1: table access setup
	logic                 valid_s1;
	logic                 is_wr_s1;
	logic [TBL_AW-1:0]    addr_s1;
	logic [CODE_W-1:0]    code_s1;

	// stage 2: table read data
	logic                 smp_s2;
	logic [CODE_W-1:0]    rdata_s2;

	logic [CODE_W-1:0]    wave_mem [TBL_DEPTH];
	logic                 mem_we;
	logic [TBL_AW-1:0]    mem_wa;
	logic [CODE_W-1:0]    mem_wd;

	// result queue
	logic [CODE_W-1:0]    oq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   oq_wr_q;
	logic [OUTQ_AW-1:0]   oq_rd_q;
	logic [OUTQ_CW-1:0]   oq_cnt_q;
	logic                 oq_push;
	logic                 oq_pop;
	logic                 smp_s1;
	logic [OUTQ_CW:0]     committed;

	assign phase_sum = phase_q + tuning_word;
	assign smp_s1    = valid_s1 && !is_wr_s1;

	// reserve a result slot for every sample still in the pipe
	assign committed = (OUTQ_CW + 1)'(oq_cnt_q) + (OUTQ_CW + 1)'(smp_s1)
		+ (OUTQ_CW + 1)'(smp_s2);
	assign q_pop     = !q_empty && !clearing_q && (committed < (OUTQ_CW + 1)'(OUTQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			phase_q    <= '0;
			valid_s1   <= 1'b0;
			smp_s2     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == TBL_AW'(TBL_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			valid_s1 <= 1'b0;
			if (q_pop) begin
				case (q_cmd.kind)
					CMD_SAMPLE: begin
						phase_q  <= phase_sum;
						valid_s1 <= 1'b1;
					end
					CMD_WRITE: begin
						valid_s1 <= 1'b1;
					end
					CMD_PHASE: begin
						phase_q <= q_cmd.phase;
					end
					default: begin
						valid_s1 <= 1'b0;
					end
				endcase
			end
			smp_s2 <= smp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			is_wr_s1 <= (q_cmd.kind == CMD_WRITE);
			code_s1  <= q_cmd.code;
			if (q_cmd.kind == CMD_WRITE) begin
				addr_s1 <= q_cmd.addr;
			end else begin
				addr_s1 <= TBL_AW'(phase_sum >> (PHASE_W - RD_BITS));
			end
		end
	end

	// one write port (clear sweep over item writes) and one read port for sample reads
	assign mem_we = clearing_q || (valid_s1 && is_wr_s1);
	assign mem_wa = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wd = clearing_q ? RESET_CODE : code_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wave_mem[mem_wa] <= mem_wd;
		end
		rdata_s2 <= wave_mem[addr_s1];
	end

	assign oq_push = smp_s2;
	assign oq_pop  = pop && !empty;
	assign empty   = (oq_cnt_q == '0);
	assign sample  = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= (oq_wr_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= rdata_s2;
		end
	end

	assign stat.clearing = clearing_q;
	assign stat.out_cnt  = oq_cnt_q;
	assign stat.inflight = {1'b0, smp_s1} + {1'b0, smp_s2};

endmodule

[rtl/core/table_phase_accumulator_dds_top.sv]
`timescale 1ns / 1ps
// path: front reg, cmd queue, stage 1, stage 2, result queue, then empty falls
// throughput: one item per cycle, sample, table write or phase load alike, while
// no queue backs up; set by one 32-bit phase add and a table write and read port
// reset: phase and tuning word clear, then a sweep loads every table entry
// with code 1241; full stays high during the sweep, register writes are taken as usual

module table_phase_accumulator_dds_top import tpdds_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 push,
	output logic                 full,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [IDX_W-1:0]     table_index,
	input  logic [CODE_W-1:0]    table_value,
	input  logic [PHASE_W-1:0]   phase_value,
	// sample side
	output logic                 empty,
	input  logic                 pop,
	output logic [CODE_W-1:0]    sample,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// tuning word register, only byte address 0 holds a register
	logic [PHASE_W-1:0] tuning_word_q;
	logic               cfg_wr;

	// front to queue
	logic               fq_push;
	cmd_t               fq_cmd;
	logic               fq_full;

	// queue to back
	logic               qb_empty;
	logic               qb_pop;
	cmd_t               qb_cmd;

	back_stat_t         bstat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
	assign prdata = (paddr == 2'd0) ? tuning_word_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuning_word_q <= '0;
		end else if (cfg_wr) begin
			tuning_word_q <= pwdata;
		end
	end

	// front: accepts and classifies, drops items that do nothing
	tpdds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.table_index (table_index),
		.table_value (table_value),
		.phase_value (phase_value),
		.clearing    (bstat.clearing),
		.q_full      (fq_full),
		.q_push      (fq_push),
		.q_cmd       (fq_cmd)
	);

	// short command queue decouples the two halves
	tpdds_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_cmd  (fq_cmd),
		.q_full  (fq_full),
		.rd_en   (qb_pop),
		.rd_cmd  (qb_cmd),
		.q_empty (qb_empty)
	);

	// back: phase accumulator, waveform table, result queue
	tpdds_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tuning_word (tuning_word_q),
		.q_empty     (qb_empty),
		.q_cmd       (qb_cmd),
		.q_pop       (qb_pop),
		.empty       (empty),
		.pop         (pop),
		.sample      (sample),
		.stat        (bstat)
	);

	// no item gets in while the table sweep runs
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.clearing |-> full)
		else $error("item accepted during table clear");

	// samples in flight never exceed the result queue
	a_outq_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(bstat.out_cnt) + 32'(bstat.inflight)) <= OUTQ_DEPTH)
		else $error("result queue overcommitted");

	// no result can exist while the sweep runs
	a_no_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.clearing |-> (empty && (bstat.inflight == 2'd0)))
		else $error("result present during table clear");

	// a result that is not popped stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sample)))
		else $error("waiting result changed");

endmodule
